/* hw/rtl/bba_pkg.sv */
`default_nettype none
package bba_pkg;

	localparam int IN_W   = 56;
	localparam int OUT_W  = 40;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 32;
	localparam int AW     = 32;
	localparam int BW     = 13;
	localparam int HW     = 7;
	localparam int RW     = 4;
	localparam int OW     = 4;
	localparam int KW     = 5;
	localparam int REQW   = 24;
	localparam int NW     = REQW + 1;
	localparam int SZW    = BW + 16;
	localparam int TGW    = 5;

	localparam logic [CFG_IW-1:0] CFG_POOL_BASE  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_BLOCK_SIZE = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_HEADER     = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_RESERVED   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_BADADDR = 2'd2;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_AK, S_AJ, S_PRD, S_PNX, S_SA1, S_SA2, S_GMUL, S_GADD,
		S_FCHK, S_FDIV, S_FTST, S_FTAG, S_FAPP, S_MCHK, S_MW, S_MWN, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_CLEAR, CMD_ACCEPT, CMD_K_STEP, CMD_J_STEP, CMD_NOMEM,
		CMD_POP_START, CMD_POP_READ, CMD_POP_NEXT, CMD_POP_COMMIT,
		CMD_SPLIT_LEFT, CMD_SPLIT_RIGHT, CMD_GRANT_MUL, CMD_GRANT_ADD,
		CMD_DIV_START, CMD_DIV_STEP, CMD_BAD, CMD_TAG_READ, CMD_TAG_CLEAR,
		CMD_APPEND, CMD_WALK_START, CMD_WALK_READ, CMD_WALK_NEXT, CMD_REMOVE,
		CMD_OK, CMD_OUT
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic act_free;
		logic k_fits;
		logic j_over;
		logic j_empty;
		logic split;
		logic pop_more;
		logic off_over;
		logic div_last;
		logic div_bad;
		logic tag_bad;
		logic m_top;
		logic m_short;
		logic m_end;
		logic m_found;
		logic out_busy;
	} stat_t;

	function automatic int top_of(int t, int n);
		int r;
		r = t;
		while (r > 0 && (1 << r) > n)
			r--;
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/bba_ctrl.sv */
`default_nettype none
module bba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire bba_pkg::stat_t st,
	output bba_pkg::cmd_t      cmd
);
	import bba_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (st.clr_last) state_d = S_IDLE;
			S_IDLE:  if (s_tvalid) state_d = st.act_free ? S_FCHK : S_AK;
			S_AK:    if (!st.k_fits) state_d = S_AJ;
			S_AJ: begin
				if (st.j_over)
					state_d = S_DONE;
				else if (!st.j_empty)
					state_d = S_PRD;
			end
			S_PRD: begin
				if (st.pop_more)
					state_d = S_PNX;
				else
					state_d = st.split ? S_SA1 : S_GMUL;
			end
			S_PNX:  state_d = S_PRD;
			S_SA1:  state_d = S_SA2;
			S_SA2:  state_d = S_AJ;
			S_GMUL: state_d = S_GADD;
			S_GADD: state_d = S_DONE;
			S_FCHK: state_d = st.off_over ? S_DONE : S_FDIV;
			S_FDIV: if (st.div_last) state_d = S_FTST;
			S_FTST: state_d = st.div_bad ? S_DONE : S_FTAG;
			S_FTAG: state_d = st.tag_bad ? S_DONE : S_FAPP;
			S_FAPP: state_d = S_MCHK;
			S_MCHK: state_d = (st.m_top || st.m_short) ? S_DONE : S_MW;
			S_MW: begin
				if (!st.m_end)
					state_d = S_MWN;
				else
					state_d = st.m_found ? S_FAPP : S_DONE;
			end
			S_MWN:  state_d = S_MW;
			S_DONE: if (!st.out_busy) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
		if (cfg_we)
			state_d = S_CLEAR;
	end

	always_comb begin
		cmd      = CMD_NONE;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd = CMD_CLEAR;
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) cmd = CMD_ACCEPT;
			end
			S_AK: cmd = CMD_K_STEP;
			S_AJ: begin
				if (st.j_over)
					cmd = CMD_NOMEM;
				else if (st.j_empty)
					cmd = CMD_J_STEP;
				else
					cmd = CMD_POP_START;
			end
			S_PRD:  cmd = st.pop_more ? CMD_POP_READ : CMD_POP_COMMIT;
			S_PNX:  cmd = CMD_POP_NEXT;
			S_SA1:  cmd = CMD_SPLIT_LEFT;
			S_SA2:  cmd = CMD_SPLIT_RIGHT;
			S_GMUL: cmd = CMD_GRANT_MUL;
			S_GADD: cmd = CMD_GRANT_ADD;
			S_FCHK: cmd = st.off_over ? CMD_BAD : CMD_DIV_START;
			S_FDIV: cmd = CMD_DIV_STEP;
			S_FTST: cmd = st.div_bad ? CMD_BAD : CMD_TAG_READ;
			S_FTAG: cmd = st.tag_bad ? CMD_BAD : CMD_TAG_CLEAR;
			S_FAPP: cmd = CMD_APPEND;
			S_MCHK: cmd = (st.m_top || st.m_short) ? CMD_OK : CMD_WALK_START;
			S_MW: begin
				if (!st.m_end)
					cmd = CMD_WALK_READ;
				else
					cmd = st.m_found ? CMD_REMOVE : CMD_OK;
			end
			S_MWN:  cmd = CMD_WALK_NEXT;
			S_DONE: if (!st.out_busy) cmd = CMD_OUT;
			default: cmd = CMD_NONE;
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/bba_datapath.sv */
`default_nettype none
module bba_datapath #(
	parameter int TOP_ORDER  = 9,
	parameter int UNIT_COUNT = 512
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [bba_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [bba_pkg::CFG_DW-1:0]  cfg_data,
	input  wire logic                        s_tuser,
	input  wire logic [bba_pkg::IN_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [bba_pkg::OUT_W-1:0]        m_tdata,
	input  wire bba_pkg::cmd_t               cmd,
	output bba_pkg::stat_t                   st
);
	import bba_pkg::*;

	localparam int TOP = top_of(TOP_ORDER, UNIT_COUNT);
	localparam int NO  = TOP + 1;
	localparam int JI  = $clog2(NO);
	localparam int UW  = $clog2(UNIT_COUNT);
	localparam int LW  = $clog2(UNIT_COUNT + 1);
	localparam int MW  = UW + BW;

	logic [AW-1:0]  base_q;
	logic [BW-1:0]  sbb_q;
	logic [HW-1:0]  hdr_q;
	logic [RW-1:0]  rsv_q;

	logic [UW-1:0]  link_mem [UNIT_COUNT];
	logic [TGW-1:0] tag_mem  [UNIT_COUNT];
	logic [UW-1:0]  link_rd_q;
	logic [TGW-1:0] tag_rd_q;

	logic [UW-1:0]  head_q [NO];
	logic [UW-1:0]  tail_q [NO];
	logic [LW-1:0]  len_q  [NO];

	logic [UW-1:0]  clr_q;
	logic [NW-1:0]  need_q;
	logic [SZW-1:0] sz_q;
	logic [KW-1:0]  k_q, j_q;
	logic [UW-1:0]  t_q, p_q, prev_q, bprev_q, bnext_q, u_q, q_q;
	logic [LW-1:0]  cnt_q, wi_q;
	logic           found_q, bidx0_q;
	logic [AW-1:0]  off_q;
	logic [3:0]     di_q;
	logic [MW-1:0]  mul_q;
	logic [OW-1:0]  ord_q;
	logic [1:0]     res_st_q, out_st_q;
	logic [AW-1:0]  res_addr_q, out_addr_q;
	logic [OW-1:0]  res_ord_q, out_ord_q;
	logic           mv_q;

	logic [BW-1:0]  b;
	logic [RW-1:0]  rord;
	logic [JI-1:0]  jx, jm1, kx;
	logic [UW-1:0]  bud;
	logic           hit;
	logic [LW-1:0]  lenj, lenk;
	logic [AW-1:0]  lim, dv;
	logic [OW-1:0]  tagk;
	logic           app_en;
	logic [JI-1:0]  app_o;
	logic [UW-1:0]  app_u;
	logic           lw_en;
	logic [UW-1:0]  lw_a, lw_d;
	logic           tw_en;
	logic [UW-1:0]  tw_a;
	logic [TGW-1:0] tw_d;

	assign b    = (sbb_q == '0) ? BW'(1) : sbb_q;
	assign rord = (rsv_q > RW'(TOP)) ? RW'(TOP) : rsv_q;
	assign jx   = j_q[JI-1:0];
	assign jm1  = jx - JI'(1);
	assign kx   = k_q[JI-1:0];
	assign bud  = u_q ^ (UW'(1) << k_q);
	assign hit  = (p_q == bud);
	assign lenj = len_q[jx];
	assign lenk = len_q[kx];
	assign lim  = AW'(b) << TOP;
	assign dv   = AW'(b) << di_q;
	assign tagk = (tag_rd_q[OW-1:0] > OW'(TOP)) ? OW'(TOP) : tag_rd_q[OW-1:0];

	always_comb begin
		app_en = 1'b0;
		app_o  = kx;
		app_u  = u_q;
		unique case (cmd)
			CMD_SPLIT_LEFT: begin
				app_en = 1'b1;
				app_o  = jm1;
				app_u  = t_q;
			end
			CMD_SPLIT_RIGHT: begin
				app_en = 1'b1;
				app_o  = jm1;
				app_u  = t_q + (UW'(1) << jm1);
			end
			CMD_APPEND: app_en = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		lw_en = 1'b0;
		lw_a  = tail_q[app_o];
		lw_d  = app_u;
		if (app_en && len_q[app_o] != '0)
			lw_en = 1'b1;
		else if (cmd == CMD_REMOVE && !hit && !bidx0_q) begin
			lw_en = 1'b1;
			lw_a  = bprev_q;
			lw_d  = bnext_q;
		end
	end

	always_comb begin
		tw_en = 1'b0;
		tw_a  = q_q;
		tw_d  = '0;
		unique case (cmd)
			CMD_CLEAR: begin
				tw_en = 1'b1;
				tw_a  = clr_q;
				tw_d  = (clr_q == '0) ? {1'b1, rord} : '0;
			end
			CMD_GRANT_MUL: begin
				tw_en = 1'b1;
				tw_a  = t_q;
				tw_d  = {1'b1, k_q[OW-1:0]};
			end
			CMD_TAG_CLEAR: tw_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (lw_en)
			link_mem[lw_a] <= lw_d;
		link_rd_q <= link_mem[p_q];
	end

	always_ff @(posedge clk) begin
		if (tw_en)
			tag_mem[tw_a] <= tw_d;
		tag_rd_q <= tag_mem[q_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			sbb_q  <= BW'(32);
			hdr_q  <= HW'(16);
			rsv_q  <= RW'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POOL_BASE:  base_q <= cfg_data;
				CFG_BLOCK_SIZE: sbb_q  <= cfg_data[BW-1:0];
				CFG_HEADER:     hdr_q  <= cfg_data[HW-1:0];
				CFG_RESERVED:   rsv_q  <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cfg_we)
			clr_q <= '0;
		else if (cmd == CMD_CLEAR)
			clr_q <= clr_q + UW'(1);
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_CLEAR: begin
				for (int o = 0; o < NO; o++) begin
					head_q[o] <= UW'(1) << o;
					tail_q[o] <= UW'(1) << o;
					len_q[o]  <= (o >= int'(rord) && o < TOP) ? LW'(1) : '0;
				end
			end
			CMD_SPLIT_LEFT, CMD_SPLIT_RIGHT, CMD_APPEND: begin
				if (len_q[app_o] == '0)
					head_q[app_o] <= app_u;
				tail_q[app_o] <= app_u;
				len_q[app_o]  <= len_q[app_o] + LW'(1);
			end
			CMD_POP_COMMIT: begin
				if (lenj > LW'(1))
					tail_q[jx] <= p_q;
				len_q[jx] <= lenj - LW'(1);
			end
			CMD_REMOVE: begin
				len_q[kx] <= lenk - LW'(2);
				if (hit) begin
					if (wi_q != '0)
						tail_q[kx] <= prev_q;
				end else begin
					if (bidx0_q)
						head_q[kx] <= bnext_q;
					tail_q[kx] <= p_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_ACCEPT: begin
				need_q <= NW'(s_tdata[23:0]) + NW'(hdr_q);
				k_q    <= '0;
				sz_q   <= SZW'(b);
				off_q  <= s_tdata[55:24] - base_q - AW'(hdr_q);
			end
			CMD_K_STEP: begin
				j_q <= k_q;
				if (st.k_fits) begin
					k_q  <= k_q + KW'(1);
					sz_q <= sz_q << 1;
				end
			end
			CMD_J_STEP: j_q <= j_q + KW'(1);
			CMD_NOMEM: begin
				res_st_q   <= ST_NOMEM;
				res_addr_q <= '0;
				res_ord_q  <= '0;
			end
			CMD_POP_START: begin
				t_q   <= tail_q[jx];
				p_q   <= head_q[jx];
				cnt_q <= lenj - LW'(1);
			end
			CMD_POP_NEXT: begin
				p_q   <= link_rd_q;
				cnt_q <= cnt_q - LW'(1);
			end
			CMD_SPLIT_RIGHT: j_q <= j_q - KW'(1);
			CMD_GRANT_MUL: mul_q <= MW'(t_q) * MW'(b);
			CMD_GRANT_ADD: begin
				res_st_q   <= ST_OK;
				res_addr_q <= base_q + AW'(mul_q) + AW'(hdr_q);
				res_ord_q  <= k_q[OW-1:0];
			end
			CMD_DIV_START: begin
				di_q <= 4'(TOP - 1);
				q_q  <= '0;
			end
			CMD_DIV_STEP: begin
				if (off_q >= dv) begin
					off_q <= off_q - dv;
					q_q   <= {q_q[UW-2:0], 1'b1};
				end else begin
					q_q   <= {q_q[UW-2:0], 1'b0};
				end
				di_q <= di_q - 4'd1;
			end
			CMD_BAD: begin
				res_st_q   <= ST_BADADDR;
				res_addr_q <= '0;
				res_ord_q  <= '0;
			end
			CMD_TAG_CLEAR: begin
				k_q   <= KW'(tagk);
				ord_q <= tagk;
				u_q   <= q_q;
			end
			CMD_WALK_START: begin
				p_q     <= head_q[kx];
				prev_q  <= '0;
				wi_q    <= '0;
				found_q <= 1'b0;
				bidx0_q <= 1'b0;
			end
			CMD_WALK_READ: begin
				if (hit) begin
					found_q <= 1'b1;
					bprev_q <= prev_q;
					bidx0_q <= (wi_q == '0);
				end
			end
			CMD_WALK_NEXT: begin
				prev_q <= p_q;
				p_q    <= link_rd_q;
				wi_q   <= wi_q + LW'(1);
				if (hit)
					bnext_q <= link_rd_q;
			end
			CMD_REMOVE: begin
				u_q <= (u_q < bud) ? u_q : bud;
				k_q <= k_q + KW'(1);
			end
			CMD_OK: begin
				res_st_q   <= ST_OK;
				res_addr_q <= '0;
				res_ord_q  <= ord_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mv_q <= 1'b0;
		else if (cmd == CMD_OUT)
			mv_q <= 1'b1;
		else if (m_tready)
			mv_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_OUT) begin
			out_st_q   <= res_st_q;
			out_addr_q <= res_addr_q;
			out_ord_q  <= res_ord_q;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {2'b00, out_ord_q, out_addr_q, out_st_q};

	always_comb begin
		st.clr_last = (clr_q == UW'(UNIT_COUNT - 1));
		st.act_free = s_tuser;
		st.k_fits   = (k_q <= KW'(TOP)) && (sz_q < SZW'(need_q));
		st.j_over   = (j_q > KW'(TOP));
		st.j_empty  = (lenj == '0);
		st.split    = (j_q > k_q);
		st.pop_more = (cnt_q > LW'(1));
		st.off_over = (off_q >= lim);
		st.div_last = (di_q == 4'd0);
		st.div_bad  = (off_q != '0) || (q_q == '0);
		st.tag_bad  = !tag_rd_q[TGW-1];
		st.m_top    = (k_q >= KW'(TOP));
		st.m_short  = (lenk < LW'(2));
		st.m_end    = (wi_q == lenk - LW'(2));
		st.m_found  = found_q || hit;
		st.out_busy = mv_q && !m_tready;
	end

endmodule
`default_nettype wire

/* hw/rtl/buddy_block_allocator.sv */
// Allocate sizes the request order, searches upward for a non-empty order, pops the tail
//   of that list by walking it, appends both halves per split down to the request order,
//   then forms the address; free divides the offset and checks the tag, then walks the
//   list at each merge level to find and remove the buddy before appending the merged block.
// Throughput: one request at a time; s_tready is high only in idle, between requests.
// Reset and every configuration write start a tag clearing pass over all UNIT_COUNT entries.
`default_nettype none
module buddy_block_allocator #(
	parameter int TOP_ORDER  = 9,
	parameter int UNIT_COUNT = 512
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic                       s_tuser,   // action
	input  wire logic [bba_pkg::IN_W-1:0]   s_tdata,   // request_size, free_address
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [bba_pkg::OUT_W-1:0]       m_tdata,   // status, granted_address, granted_order
	input  wire logic                       cfg_we,
	input  wire logic [bba_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [bba_pkg::CFG_DW-1:0] cfg_data
);
	import bba_pkg::*;

	cmd_t  cmd;
	stat_t st;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bba_datapath #(
		.TOP_ORDER  (TOP_ORDER),
		.UNIT_COUNT (UNIT_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
`default_nettype wire
